### rtl/serial_radio_frame_parser_defines.svh
// Assertion macros shared by the serial radio frame parser.
`ifndef SERIAL_RADIO_FRAME_PARSER_DEFINES_SVH
`define SERIAL_RADIO_FRAME_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SRFP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SRFP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SRFP_ASSERT(lbl, clk, rst_n, prop)
`define SRFP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/srfp_pkg.sv
`default_nettype none
package srfp_pkg;
  localparam int unsigned CAPTURE_BYTES_DEF = 11;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] HDR_RPS   = 8'h20;
  localparam logic [7:0] HDR_4BS   = 8'h22;
  localparam logic [7:0] HDR_TEACH = 8'h62;
  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] RPS_MASK  = 8'h0F;

  localparam logic [7:0] RADIO_TYPE_RESET = 8'd1;
  localparam logic [7:0] ERP2_TYPE_RESET  = 8'd10;

  localparam logic [7:0] CFG_RADIO_TYPE = 8'd0;
  localparam logic [7:0] CFG_ERP2_TYPE  = 8'd1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HDR_CRC  = 2'd1;
  localparam logic [1:0] ST_BAD_RHDR = 2'd2;
  localparam logic [1:0] ST_DATA_CRC = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT, PH_HDR, PH_HCRC, PH_DATA, PH_OPT, PH_DCRC
  } phase_t;

  typedef struct packed {
    logic [7:0] radio_type;
    logic [7:0] erp2_type;
  } cfg_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction
endpackage
`default_nettype wire

### rtl/srfp_front.sv
`default_nettype none
`include "serial_radio_frame_parser_defines.svh"
module srfp_front
  import srfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            q_valid,
  input  wire logic       q_ready,
  output logic [7:0]      q_byte
);
  logic [7:0] mem_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_byte   = mem_r[rptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= in_rx_byte;
    end
  end

  `SRFP_ASSERT(a_count_max, clk, rst_n, count_r != 2'd3)
  `SRFP_ASSERT(a_count_up, clk, rst_n, (push && !pop) |=> count_r == $past(count_r) + 2'd1)
  `SRFP_ASSERT(a_count_dn, clk, rst_n, (pop && !push) |=> count_r == $past(count_r) - 2'd1)
endmodule
`default_nettype wire

### rtl/srfp_engine.sv
`default_nettype none
module srfp_engine
  import srfp_pkg::*;
#(
  parameter int unsigned CAPTURE_BYTES = CAPTURE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire logic [7:0]  q_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_packet_type,
  output logic [15:0]      out_data_length,
  output logic [7:0]       out_option_length,
  output logic [7:0]       out_radio_header,
  output logic [31:0]      out_sender_id,
  output logic [31:0]      out_payload,
  output logic             out_repeat_flag
);
  phase_t      phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [16:0] cnt_inc;
  logic [7:0]  hdr_r [4];
  logic [7:0]  crc_r, crc_nxt, crc_new;
  logic [7:0]  cap_r [CAPTURE_BYTES];
  logic        go, clear_cap, cap_we, hdr_we;
  logic [7:0]  cap0;
  logic [15:0] hdr_len;
  logic        is_radio, rhdr_ok;
  logic        emit;
  logic [1:0]  st;
  logic        full;
  logic        valid_r;
  logic [1:0]  status_r;
  logic [7:0]  ptype_r, olen_r, rhdr_r;
  logic [15:0] dlen_r;
  logic [31:0] id_r, pay_r, id_v, pay_v;
  logic        rep_r, rep_v;
  logic [7:0]  rh_v;
  logic [7:0]  c1, c2, c3, c4, c5, c6, c7, c8;

  assign q_ready = !valid_r || out_ready;
  assign go      = q_valid && q_ready;
  assign crc_new = crc8_step(crc_r, q_byte);
  assign cnt_inc = {1'b0, cnt_r} + 17'd1;
  assign hdr_len = {hdr_r[0], hdr_r[1]};
  assign is_radio = (hdr_r[3] == cfg.radio_type) || (hdr_r[3] == cfg.erp2_type);
  assign cap0 = (phase_r == PH_DATA && cnt_r == 16'd0) ? q_byte : cap_r[0];
  assign rhdr_ok = (cap0 == HDR_RPS) || (cap0 == HDR_4BS) || (cap0 == HDR_TEACH);

  // Field selection for a good frame; teach-in shifts everything by two bytes.
  always_comb begin
    if (cap_r[0] == HDR_TEACH) begin
      c1 = cap_r[3]; c2 = cap_r[4]; c3 = cap_r[5]; c4 = cap_r[6];
      c5 = cap_r[7]; c6 = cap_r[8]; c7 = cap_r[9]; c8 = cap_r[10];
    end else begin
      c1 = cap_r[1]; c2 = cap_r[2]; c3 = cap_r[3]; c4 = cap_r[4];
      c5 = cap_r[5]; c6 = cap_r[6]; c7 = cap_r[7]; c8 = cap_r[8];
    end
    rh_v  = 8'd0;
    id_v  = 32'd0;
    pay_v = 32'd0;
    rep_v = 1'b0;
    if (is_radio) begin
      rh_v = cap_r[0];
      id_v = {c1, c2, c3, c4};
      if (cap_r[0] == HDR_RPS) begin
        pay_v = {24'd0, c5 & RPS_MASK};
        rep_v = c5[7];
      end else begin
        pay_v = {c8, c7, c6, c5};
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    clear_cap = 1'b0;
    cap_we    = 1'b0;
    hdr_we    = 1'b0;
    full      = 1'b0;
    emit      = 1'b0;
    st        = ST_OK;
    unique case (phase_r)
      PH_HUNT: begin
        if (q_byte == SYNC_BYTE) begin
          phase_nxt = PH_HDR;
          cnt_nxt   = 16'd0;
          crc_nxt   = 8'd0;
          clear_cap = 1'b1;
        end
      end
      PH_HDR: begin
        hdr_we  = 1'b1;
        crc_nxt = crc_new;
        cnt_nxt = cnt_inc[15:0];
        if (cnt_inc >= 17'd4) begin
          phase_nxt = PH_HCRC;
        end
      end
      PH_HCRC: begin
        if (q_byte != crc_r) begin
          emit      = 1'b1;
          st        = ST_HDR_CRC;
          phase_nxt = PH_HUNT;
        end else begin
          crc_nxt = 8'd0;
          cnt_nxt = 16'd0;
          if (hdr_len != 16'd0) begin
            phase_nxt = PH_DATA;
          end else if (is_radio && !rhdr_ok) begin
            emit      = 1'b1;
            st        = ST_BAD_RHDR;
            phase_nxt = PH_HUNT;
          end else begin
            phase_nxt = (hdr_r[2] != 8'd0) ? PH_OPT : PH_DCRC;
          end
        end
      end
      PH_DATA: begin
        cap_we  = 1'b1;
        crc_nxt = crc_new;
        cnt_nxt = cnt_inc[15:0];
        if (cnt_inc >= {1'b0, hdr_len}) begin
          if (is_radio && !rhdr_ok) begin
            emit      = 1'b1;
            st        = ST_BAD_RHDR;
            phase_nxt = PH_HUNT;
          end else begin
            cnt_nxt   = 16'd0;
            phase_nxt = (hdr_r[2] != 8'd0) ? PH_OPT : PH_DCRC;
          end
        end
      end
      PH_OPT: begin
        crc_nxt = crc_new;
        cnt_nxt = cnt_inc[15:0];
        if (cnt_inc >= {9'd0, hdr_r[2]}) begin
          phase_nxt = PH_DCRC;
        end
      end
      PH_DCRC: begin
        phase_nxt = PH_HUNT;
        emit      = 1'b1;
        if (q_byte != crc_r) begin
          st = ST_DATA_CRC;
        end else begin
          full = 1'b1;
        end
      end
      default: phase_nxt = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r   <= 16'd0;
      crc_r   <= 8'd0;
      valid_r <= 1'b0;
    end else begin
      if (go) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        crc_r   <= crc_nxt;
      end
      if (go && emit) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Stores reset to zero because a radio frame with no data reads its header byte as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        hdr_r[i] <= 8'd0;
      end
      for (int i = 0; i < CAPTURE_BYTES; i++) begin
        cap_r[i] <= 8'd0;
      end
    end else if (go) begin
      if (hdr_we) begin
        hdr_r[cnt_r[1:0]] <= q_byte;
      end
      for (int i = 0; i < CAPTURE_BYTES; i++) begin
        if (clear_cap) begin
          cap_r[i] <= 8'd0;
        end else if (cap_we && cnt_r == 16'(i)) begin
          cap_r[i] <= q_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      status_r <= st;
      ptype_r  <= hdr_r[3];
      dlen_r   <= hdr_len;
      olen_r   <= hdr_r[2];
      rhdr_r   <= (st == ST_BAD_RHDR) ? cap0 : (full ? rh_v : 8'd0);
      id_r     <= full ? id_v : 32'd0;
      pay_r    <= full ? pay_v : 32'd0;
      rep_r    <= full ? rep_v : 1'b0;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_packet_type   = ptype_r;
  assign out_data_length   = dlen_r;
  assign out_option_length = olen_r;
  assign out_radio_header  = rhdr_r;
  assign out_sender_id     = id_r;
  assign out_payload       = pay_r;
  assign out_repeat_flag   = rep_r;
endmodule
`default_nettype wire

### rtl/serial_radio_frame_parser.sv
`default_nettype none
// Serial radio frame parser. Feed received serial bytes on the in_ channel,
// one byte per transfer. The block hunts for the sync byte, checks the header
// and data CRC-8, and decodes radio telegrams. Each frame that completes or
// fails gives one transfer on the out_ channel with a status code and the
// decoded fields; bytes outside a frame give nothing.
// Throughput is one byte per cycle while no result waits with out_ready low:
// each byte takes one pass of the frame engine, which does one CRC step and
// one capture per cycle. The byte that completes the frame passes through
// the two-entry input queue, and the engine loads the output register as it
// consumes it; out_valid then rises.
// When out_ready is low, a waiting result holds the engine; the input queue
// then fills and in_ready drops once it holds two bytes.
// Reset (synchronous, rst_n low) returns the parser to sync hunt, empties the
// queue and the output register, and sets the radio type codes to 1 and 10.
// The cfg_ channel is always ready; index 0 writes the radio type code,
// index 1 the ERP2 type code, other indexes are ignored. Write it only while
// the block is idle.
module serial_radio_frame_parser
  import srfp_pkg::*;
#(
  parameter int unsigned CAPTURE_BYTES = CAPTURE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_packet_type,
  output logic [15:0]      out_data_length,
  output logic [7:0]       out_option_length,
  output logic [7:0]       out_radio_header,
  output logic [31:0]      out_sender_id,
  output logic [31:0]      out_payload,
  output logic             out_repeat_flag,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  cfg_t       cfg_r;
  logic       q_valid, q_ready;
  logic [7:0] q_byte;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radio_type <= RADIO_TYPE_RESET;
      cfg_r.erp2_type  <= ERP2_TYPE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_RADIO_TYPE) begin
        cfg_r.radio_type <= cfg_data;
      end else if (cfg_index == CFG_ERP2_TYPE) begin
        cfg_r.erp2_type <= cfg_data;
      end
    end
  end

  srfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_byte     (q_byte)
  );

  srfp_engine #(
    .CAPTURE_BYTES (CAPTURE_BYTES)
  ) u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_byte            (q_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_packet_type   (out_packet_type),
    .out_data_length   (out_data_length),
    .out_option_length (out_option_length),
    .out_radio_header  (out_radio_header),
    .out_sender_id     (out_sender_id),
    .out_payload       (out_payload),
    .out_repeat_flag   (out_repeat_flag)
  );
endmodule
`default_nettype wire
